[hw/rtl/bounded_ordered_list_engine_macros.svh]
// Assertion macros used by the assertion checker of the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BOLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BOLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bole_pkg.sv]
// Package with the types, codes and sizes of the ordered list engine.
`default_nettype none

package bole_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = 5;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 3;
    localparam int S_FIELDS_W = ACTION_W + VALUE_BITS + CNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + CNT_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LENGTH   = 3'd0,
        ACT_INS_HEAD = 3'd1,
        ACT_INS_POS  = 3'd2,
        ACT_INS_TAIL = 3'd3,
        ACT_SEARCH   = 3'd4,
        ACT_DEL_HEAD = 3'd5,
        ACT_DEL_POS  = 3'd6,
        ACT_DEL_TAIL = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic load;
        logic execute;
    } dp_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/bole_ctrl.sv]
// Sequencer of the ordered list engine: request intake, execute step, result valid.
`default_nettype none

module bole_ctrl
    import bole_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   s_tready_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        cmd.load      = 1'b0;
        cmd.execute   = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    cmd.load      = 1'b1;
                    state_next    = S_EXEC;
                    s_tready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.execute   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

[hw/rtl/bole_dp.sv]
// Datapath of the ordered list engine: entry cells, length, limit and result register.
`default_nettype none

module bole_dp
    import bole_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic [CNT_W-1:0]     cfg_data,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    action_t                       action_reg;
    logic signed [VALUE_BITS-1:0]  value_reg;
    logic [CNT_W-1:0]              pos_reg;
    logic signed [VALUE_BITS-1:0]  cell_reg  [CAPACITY];
    logic signed [VALUE_BITS-1:0]  cell_next [CAPACITY];
    logic signed [VALUE_BITS-1:0]  cell_prev [CAPACITY];
    logic signed [VALUE_BITS-1:0]  cell_succ [CAPACITY];
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              limit_reg;
    logic [CNT_W-1:0]              eff_limit;
    logic [CNT_W:0]                count_plus;
    logic [CAPACITY-1:0]           match;
    logic                          hit_any;
    logic [IDX_W-1:0]              hit_idx;
    logic [IDX_W-1:0]              op_idx;
    logic [IDX_W-1:0]              pos_idx;
    logic                          do_ins;
    logic                          do_del;
    status_t                       status;
    logic [CNT_W-1:0]              found;
    logic [M_TDATA_W-1:0]          result_reg;

    always_comb
    begin
        eff_limit  = (limit_reg > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : limit_reg;
        count_plus = {1'b0, count_reg} + (CNT_W+1)'(1);
        pos_idx    = IDX_W'(pos_reg - CNT_W'(1));

        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (cell_reg[i] == value_reg) && (CNT_W'(i) < count_reg);
        end

        // Priority encoder: the lowest matching cell wins.
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end

        status = ST_OK;
        found  = '0;
        do_ins = 1'b0;
        do_del = 1'b0;
        op_idx = '0;
        unique case (action_reg) inside
            ACT_INS_HEAD, ACT_INS_POS, ACT_INS_TAIL:
            begin
                if (count_reg >= eff_limit)
                begin
                    status = ST_FULL;
                end
                else if (action_reg == ACT_INS_HEAD)
                begin
                    do_ins = 1'b1;
                end
                else if (action_reg == ACT_INS_TAIL)
                begin
                    do_ins = 1'b1;
                    op_idx = count_reg[IDX_W-1:0];
                end
                else if ((pos_reg != '0) && ({1'b0, pos_reg} <= count_plus))
                begin
                    do_ins = 1'b1;
                    op_idx = pos_idx;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            ACT_SEARCH:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (hit_any)
                begin
                    found = {1'b0, hit_idx} + CNT_W'(1);
                end
                else
                begin
                    status = ST_NOTFOUND;
                end
            end
            ACT_DEL_HEAD, ACT_DEL_POS, ACT_DEL_TAIL:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (action_reg == ACT_DEL_HEAD)
                begin
                    do_del = 1'b1;
                end
                else if (action_reg == ACT_DEL_TAIL)
                begin
                    do_del = 1'b1;
                    op_idx = IDX_W'(count_reg - CNT_W'(1));
                end
                else if ((pos_reg != '0) && (pos_reg <= count_reg))
                begin
                    do_del = 1'b1;
                    op_idx = pos_idx;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            default:
            begin
            end
        endcase

        // Each cell takes its neighbor toward the head, its neighbor toward the tail,
        // the new value, or holds.
        cell_prev[0]          = value_reg;
        cell_succ[CAPACITY-1] = cell_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            cell_prev[i]   = cell_reg[i-1];
            cell_succ[i-1] = cell_reg[i];
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins && (IDX_W'(i) > op_idx))
            begin
                cell_next[i] = cell_prev[i];
            end
            else if (do_ins && (IDX_W'(i) == op_idx))
            begin
                cell_next[i] = value_reg;
            end
            else if (do_del && (IDX_W'(i) >= op_idx))
            begin
                cell_next[i] = cell_succ[i];
            end
        end

        if (do_ins)
        begin
            count_next = count_plus[CNT_W-1:0];
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= CNT_W'(CAPACITY);
        end
        else
        begin
            if (cmd.execute)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(s_tdata[ACTION_W-1:0]);
            value_reg  <= s_tdata[ACTION_W +: VALUE_BITS];
            pos_reg    <= s_tdata[ACTION_W+VALUE_BITS +: CNT_W];
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
            result_reg <= {{(M_TDATA_W-M_FIELDS_W){1'b0}}, count_next, found, status};
        end
    end

    assign m_tdata = result_reg;

endmodule

`default_nettype wire

[hw/rtl/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine.
`default_nettype none

// Keeps an ordered list of up to sixteen signed 32-bit values and answers one
// request at a time with one result (status, found position, length). Each
// request is accepted in the idle state and then executed in the execute state,
// in which every entry cell shifts or holds in parallel and a search resolves
// through a comparator per cell and a priority encoder. The next request is
// accepted in the cycle after execute, so a new request is not taken before the
// last one has executed. A result held in the output register that the
// downstream side has not taken delays only the execute step. The capacity
// limit register resets to sixteen and is written through the cfg channel,
// which is always ready.
module bounded_ordered_list_engine
    import bole_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: action[2:0], value[34:3], position[39:35].
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // Fields from bit 0: status[2:0], found_position[7:3], length[12:8].
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bole_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/bole_checker.sv]
// Port-level assertions for the ordered list engine and the bind that attaches them.
`default_nettype none

`include "bounded_ordered_list_engine_macros.svh"

module bole_checker
    import bole_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]    res_found;
    logic [CNT_W-1:0]    res_length;

    assign res_status = m_tdata[STATUS_W-1:0];
    assign res_found  = m_tdata[STATUS_W +: CNT_W];
    assign res_length = m_tdata[STATUS_W+CNT_W +: CNT_W];

    `BOLE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BOLE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready,
        !s_tready, "request accepted while another is in progress")
    `BOLE_ASSERT_NOW(a_length_bound, clk, rst_n, m_tvalid,
        res_length <= CNT_W'(CAPACITY), "length above capacity")
    `BOLE_ASSERT_NOW(a_found_ok, clk, rst_n, m_tvalid && (res_found != '0),
        (res_status == ST_OK) && (res_found <= res_length), "found position inconsistent")
    `BOLE_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid,
        m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0, "result padding not zero")

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/bounded_ordered_list_checker.sv]
// Checker that predicts and compares every result of the ordered list engine.
module bounded_ordered_list_checker
    import bole_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // Fields from bit 0: action[2:0], value[34:3], position[39:35].
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: status[2:0], found_position[7:3], length[12:8].
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data,
    output int                   failures,
    output int                   outstanding,
    output int                   list_length
);

    typedef struct {
        status_t          status;
        logic [CNT_W-1:0] found;
        logic [CNT_W-1:0] length;
    } list_result_t;

    logic [VALUE_BITS-1:0] list_entries [CAPACITY];
    int                    held = 0;
    int                    capacity_limit = CAPACITY;
    list_result_t          awaited_results [$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
        list_length = 0;
    end

    task automatic predict_list_action(input action_t act, input logic [VALUE_BITS-1:0] val,
                                       input logic [CNT_W-1:0] pos, output list_result_t res);
        int idx;
        int i;
        int lim;
        res.status = ST_OK;
        res.found  = '0;
        lim = (capacity_limit > CAPACITY) ? CAPACITY : capacity_limit;
        idx = -1;
        case (act)
            ACT_INS_HEAD, ACT_INS_POS, ACT_INS_TAIL:
            begin
                if (held >= lim)
                    res.status = ST_FULL;
                else if (act == ACT_INS_HEAD)
                    idx = 0;
                else if (act == ACT_INS_TAIL)
                    idx = held;
                else if (pos >= 1 && pos <= held + 1)
                    idx = pos - 1;
                else
                    res.status = ST_RANGE;
                if (idx >= 0)
                begin
                    for (i = held; i > idx; i--)
                        list_entries[i] = list_entries[i - 1];
                    list_entries[idx] = val;
                    held++;
                end
            end
            ACT_SEARCH:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.status = ST_NOTFOUND;
                    for (i = 0; i < held; i++)
                    begin
                        if (res.found == 0 && list_entries[i] == val)
                        begin
                            res.found  = CNT_W'(i + 1);
                            res.status = ST_OK;
                        end
                    end
                end
            end
            ACT_DEL_HEAD, ACT_DEL_POS, ACT_DEL_TAIL:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else if (act == ACT_DEL_HEAD)
                    idx = 0;
                else if (act == ACT_DEL_TAIL)
                    idx = held - 1;
                else if (pos >= 1 && pos <= held)
                    idx = pos - 1;
                else
                    res.status = ST_RANGE;
                if (idx >= 0)
                begin
                    for (i = idx; i + 1 < held; i++)
                        list_entries[i] = list_entries[i + 1];
                    held--;
                end
            end
            default:
            begin
            end
        endcase
        res.length = CNT_W'(held);
    endtask

    always @(posedge clk)
    begin : monitor
        list_result_t          want;
        list_result_t          next_res;
        logic [STATUS_W-1:0]   got_status;
        logic [CNT_W-1:0]      got_found;
        logic [CNT_W-1:0]      got_length;
        if (!rst_n)
        begin
            held           = 0;
            capacity_limit = CAPACITY;
            awaited_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_status = m_tdata[STATUS_W-1:0];
                got_found  = m_tdata[STATUS_W +: CNT_W];
                got_length = m_tdata[STATUS_W + CNT_W +: CNT_W];
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d found %0d length %0d",
                             $time, got_status, got_found, got_length);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got_status != want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got_status);
                        failures++;
                    end
                    if (got_found != want.found)
                    begin
                        $display("%0t: found_position mismatch, expected %0d actual %0d",
                                 $time, want.found, got_found);
                        failures++;
                    end
                    if (got_length != want.length)
                    begin
                        $display("%0t: length mismatch, expected %0d actual %0d",
                                 $time, want.length, got_length);
                        failures++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity_limit = cfg_data;
            if (s_tvalid && s_tready)
            begin
                predict_list_action(action_t'(s_tdata[ACTION_W-1:0]),
                                    s_tdata[ACTION_W +: VALUE_BITS],
                                    s_tdata[ACTION_W + VALUE_BITS +: CNT_W], next_res);
                awaited_results.push_back(next_res);
            end
        end
        outstanding = awaited_results.size();
        list_length = held;
    end

endmodule

[tb/bounded_ordered_list_engine_tb.sv]
// Top of the ordered list engine testbench: clock, reset, requests and verdict.
module bounded_ordered_list_engine_tb;
    import bole_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int PHASES         = 14;
    localparam int PHASE_REQUESTS = 116;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } request_mix_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data = '0;

    int                    failures;
    int                    outstanding;
    int                    list_length;
    int                    quiet_cycles = 0;
    bit                    steady = 1'b0;
    logic [VALUE_BITS-1:0] recent_values [$];

    bounded_ordered_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bounded_ordered_list_checker list_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding),
        .list_length (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready = steady || ($urandom_range(99) >= 27);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(input action_t act, input logic [VALUE_BITS-1:0] val,
                                input logic [CNT_W-1:0] pos);
        while (!steady && $urandom_range(99) < 27)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = S_TDATA_W'({pos, val, act});
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (act == ACT_INS_HEAD || act == ACT_INS_POS || act == ACT_INS_TAIL)
        begin
            recent_values.push_back(val);
            if (recent_values.size() > 32)
                void'(recent_values.pop_front());
        end
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] lim);
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg_data  = lim;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 45 && recent_values.size() > 0)
            return recent_values[$urandom_range(recent_values.size() - 1)];
        if (r < 60)
            return VALUE_BITS'($urandom_range(7));
        return $urandom;
    endfunction

    task automatic random_request(input request_mix_t mix);
        int      r;
        action_t act;
        r = $urandom_range(99);
        if (mix == MIX_BALANCED)
            act = action_t'($urandom_range(7));
        else if (r < 8)
            act = ACT_LENGTH;
        else if (r < 22)
            act = ACT_SEARCH;
        else if ((r < 75) == (mix == MIX_FILL))
        begin
            case ($urandom_range(2))
                0: act = ACT_INS_HEAD;
                1: act = ACT_INS_POS;
                default: act = ACT_INS_TAIL;
            endcase
        end
        else
        begin
            case ($urandom_range(2))
                0: act = ACT_DEL_HEAD;
                1: act = ACT_DEL_POS;
                default: act = ACT_DEL_TAIL;
            endcase
        end
        send_request(act, pick_value(),
                     ($urandom_range(9) < 8) ? CNT_W'($urandom_range(list_length + 1))
                                             : CNT_W'($urandom_range(31)));
    endtask

    initial
    begin : stimulus
        int           phase_limits [PHASES] = '{16, 1, 0, 31, 16, 2, 17, 7, 16, 4, 24, 12, 16, 9};
        request_mix_t mix;
        int           p;
        int           n;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(ACT_LENGTH, 32'h0, 5'd0);
        send_request(ACT_SEARCH, 32'h0, 5'd0);
        send_request(ACT_DEL_HEAD, 32'h0, 5'd0);
        send_request(ACT_DEL_POS, 32'h0, 5'd1);
        send_request(ACT_DEL_TAIL, 32'h0, 5'd0);
        send_request(ACT_INS_POS, 32'h1234_5678, 5'd0);
        send_request(ACT_INS_POS, 32'h1234_5678, 5'd2);
        send_request(ACT_INS_POS, 32'h8000_0000, 5'd1);
        send_request(ACT_INS_HEAD, 32'h7FFF_FFFF, 5'd0);
        send_request(ACT_INS_TAIL, 32'hFFFF_FFFF, 5'd0);
        send_request(ACT_INS_POS, 32'h0000_0000, 5'd4);
        send_request(ACT_INS_POS, 32'hFFFF_FFFF, 5'd2);
        send_request(ACT_SEARCH, 32'hFFFF_FFFF, 5'd0);
        send_request(ACT_SEARCH, 32'h0000_0001, 5'd0);
        send_request(ACT_SEARCH, 32'h0000_0000, 5'd0);
        send_request(ACT_DEL_POS, 32'h0, 5'd0);
        send_request(ACT_DEL_POS, 32'h0, 5'd6);
        send_request(ACT_DEL_POS, 32'h0, 5'd31);
        send_request(ACT_DEL_POS, 32'h0, 5'd5);
        send_request(ACT_DEL_POS, 32'h0, 5'd1);
        send_request(ACT_DEL_HEAD, 32'h0, 5'd0);
        send_request(ACT_DEL_TAIL, 32'h0, 5'd0);
        send_request(ACT_LENGTH, 32'h0, 5'd0);
        // The list keeps its entry while the limit drops to zero, and a full list
        // wins over a bad position.
        write_limit(5'd0);
        send_request(ACT_INS_POS, 32'hA5A5_5A5A, 5'd31);
        send_request(ACT_INS_HEAD, 32'h5A5A_A5A5, 5'd0);
        send_request(ACT_LENGTH, 32'h0, 5'd0);

        for (p = 0; p < PHASES; p++)
        begin
            steady = (p == 4 || p == 5);
            case (p % 3)
                0: mix = MIX_FILL;
                1: mix = MIX_BALANCED;
                default: mix = MIX_DRAIN;
            endcase
            write_limit((p == PHASES - 1) ? CNT_W'($urandom_range(1, 16))
                                          : CNT_W'(phase_limits[p]));
            for (n = 0; n < PHASE_REQUESTS; n++)
                random_request(mix);
        end
        steady = 1'b0;

        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
